// ===== src/dso_pkg.sv =====
// ----------------------------------------------------------------------------
// dso_pkg: shared widths, constants and arctangent table
// Widths of the accumulators, the normalized vector and the angle word, and
// the arctangent table used by the iterative CORDIC unit.
// ----------------------------------------------------------------------------
package dso_pkg;

    localparam int ACC_WIDTH    = 32;
    localparam int CORDIC_STEPS = 16;

    localparam int SEP_W     = 16;
    localparam int IN_W      = 16;
    localparam int SUM_W     = 33;
    localparam int YAW_W     = 16;
    localparam int DX_W      = ACC_WIDTH + 2;
    localparam int DY_W      = ACC_WIDTH + 1;

    // normalized vector: top set bit lands on bit NORM_W-1
    localparam int NORM_W      = 60;
    localparam int NORM_STAGES = 6;
    localparam int NSTG_W      = $clog2(NORM_STAGES);
    localparam int NSH_W       = NORM_STAGES + 1;

    localparam int CORDIC_W  = 64;
    localparam int STEP_W    = $clog2(CORDIC_STEPS);
    localparam int TAB_LEN   = 24;
    localparam int TAB_IDX_W = $clog2(TAB_LEN);

    // angle in units of pi / 2^31
    localparam int Z_W = 34;
    localparam logic signed [Z_W-1:0] Z_PI      = Z_W'(64'sd2147483648);
    localparam logic signed [Z_W-1:0] Z_HALF_PI = Z_W'(64'sd1073741824);

    localparam logic [YAW_W-1:0] YAW_ZERO    = YAW_W'(0);
    localparam logic [YAW_W-1:0] YAW_HALF_PI = YAW_W'(16384);
    localparam logic [YAW_W-1:0] YAW_PI      = YAW_W'(32768);

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    function automatic logic signed [Z_W-1:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = Z_W'(536870912);
            5'd1:    v = Z_W'(316933406);
            5'd2:    v = Z_W'(167458907);
            5'd3:    v = Z_W'(85004756);
            5'd4:    v = Z_W'(42667331);
            5'd5:    v = Z_W'(21354465);
            5'd6:    v = Z_W'(10679838);
            5'd7:    v = Z_W'(5340245);
            5'd8:    v = Z_W'(2670163);
            5'd9:    v = Z_W'(1335087);
            5'd10:   v = Z_W'(667544);
            5'd11:   v = Z_W'(333772);
            5'd12:   v = Z_W'(166886);
            5'd13:   v = Z_W'(83443);
            5'd14:   v = Z_W'(41722);
            5'd15:   v = Z_W'(20861);
            5'd16:   v = Z_W'(10430);
            5'd17:   v = Z_W'(5215);
            5'd18:   v = Z_W'(2608);
            5'd19:   v = Z_W'(1304);
            5'd20:   v = Z_W'(652);
            5'd21:   v = Z_W'(326);
            5'd22:   v = Z_W'(163);
            5'd23:   v = Z_W'(81);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/dual_sensor_odometry_pose.sv =====
// ----------------------------------------------------------------------------
// dual_sensor_odometry_pose: two-sensor odometry with CORDIC heading
// Accumulates left and right sensor shifts, reports the midpoint sums and the
// heading angle of the left-minus-right vector.
// ----------------------------------------------------------------------------
// Each input item adds four 16-bit shift counts to four saturating position
// accumulators and yields one result item: the x and y sums of the two sensor
// positions (midpoint in half counts) and the heading of the vector from the
// right sensor to the left one, 0..pi with 32768 standing for pi. The sensors
// start 100 counts apart on the x axis; a write on the cfg channel changes
// that spacing and takes effect on each item that forms its vector after the
// write. When the sensors coincide the result flags degenerate and repeats
// the last heading. In the general case an item steps through forming and
// classifying the vector, six normalizing shift steps and a hand-off, one
// CORDIC micro-rotation per cycle for CORDIC_STEPS iterations (16), rounding
// the angle, and loading the output register once it is free. A new item is
// taken only after the last one has loaded the output register. An
// axis-aligned or degenerate vector skips the normalizer and CORDIC unit and
// goes straight from classification to the output register. s_ready is high
// only while no item is in flight; a finished result waits in the output
// register, so a new item is taken meanwhile.
// ----------------------------------------------------------------------------
module dual_sensor_odometry_pose (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [dso_pkg::IN_W-1:0]   s_left_dx,
    input  logic signed [dso_pkg::IN_W-1:0]   s_left_dy,
    input  logic signed [dso_pkg::IN_W-1:0]   s_right_dx,
    input  logic signed [dso_pkg::IN_W-1:0]   s_right_dy,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [dso_pkg::SUM_W-1:0]  m_mid_x_sum,
    output logic signed [dso_pkg::SUM_W-1:0]  m_mid_y_sum,
    output logic [dso_pkg::YAW_W-1:0]         m_yaw_code,
    output logic                              m_degenerate,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dso_pkg::SEP_W-1:0]         cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIFF = 3'd1;
    localparam logic [2:0] ST_SORT = 3'd2;
    localparam logic [2:0] ST_NORM = 3'd3;
    localparam logic [2:0] ST_ROT  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    localparam int AW = dso_pkg::ACC_WIDTH;
    localparam int WIDE_W = 64;
    localparam logic signed [WIDE_W-1:0] SUM_HI = 64'sd4294967295;
    localparam logic signed [WIDE_W-1:0] SUM_LO = -64'sd4294967296;
    localparam logic signed [dso_pkg::Z_W-1:0] ROUND_HALF = dso_pkg::Z_W'(32768);

    // saturating accumulate of one sign-extended shift count
    function automatic logic signed [AW-1:0] sat_add(input logic signed [AW-1:0] a,
                                                     input logic signed [dso_pkg::IN_W-1:0] d);
        logic signed [AW:0] s;
        logic signed [AW-1:0] r;
        s = (AW+1)'(a) + (AW+1)'(d);
        if (s[AW] != s[AW-1]) begin
            r = s[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
        end else begin
            r = s[AW-1:0];
        end
        return r;
    endfunction

    // sum of two positions, clamped to the output range
    function automatic logic signed [dso_pkg::SUM_W-1:0] sum_sat(input logic signed [AW-1:0] a,
                                                                 input logic signed [AW-1:0] b);
        logic signed [WIDE_W-1:0] s;
        logic signed [WIDE_W-1:0] c;
        s = WIDE_W'(a) + WIDE_W'(b);
        if (s > SUM_HI) begin
            c = SUM_HI;
        end else if (s < SUM_LO) begin
            c = SUM_LO;
        end else begin
            c = s;
        end
        return c[dso_pkg::SUM_W-1:0];
    endfunction

    logic [2:0] state_reg, state_next;

    logic signed [AW-1:0] lx_reg, lx_next;
    logic signed [AW-1:0] ly_reg, ly_next;
    logic signed [AW-1:0] rx_reg, rx_next;
    logic signed [AW-1:0] ry_reg, ry_next;
    logic [dso_pkg::SEP_W-1:0] sep_reg, sep_next;
    logic [dso_pkg::YAW_W-1:0] last_yaw_reg, last_yaw_next;

    logic signed [dso_pkg::DX_W-1:0] dx_reg, dx_next;
    logic [dso_pkg::DY_W-1:0]        dy_reg, dy_next;
    logic signed [dso_pkg::Z_W-1:0]  z0_reg, z0_next;

    logic signed [dso_pkg::SUM_W-1:0] sum_x_reg, sum_x_next;
    logic signed [dso_pkg::SUM_W-1:0] sum_y_reg, sum_y_next;
    logic [dso_pkg::YAW_W-1:0]        yaw_reg, yaw_next;
    logic                             degen_reg, degen_next;

    logic                             m_valid_reg, m_valid_next;
    logic signed [dso_pkg::SUM_W-1:0] m_x_reg, m_x_next;
    logic signed [dso_pkg::SUM_W-1:0] m_y_reg, m_y_next;
    logic [dso_pkg::YAW_W-1:0]        m_yaw_reg, m_yaw_next;
    logic                             m_degen_reg, m_degen_next;

    logic signed [dso_pkg::DY_W-1:0] dy_raw;
    logic [dso_pkg::DX_W-1:0]        dx_neg;
    logic signed [dso_pkg::Z_W-1:0]  z_clamp;
    logic signed [dso_pkg::Z_W-1:0]  z_round;

    logic                        norm_start;
    logic [dso_pkg::NORM_W-1:0]  norm_a_in, norm_b_in;
    logic [dso_pkg::NORM_W-1:0]  norm_a, norm_b;
    dso_pkg::unit_stat_t         norm_stat;

    logic                        cordic_start;
    logic signed [dso_pkg::Z_W-1:0] cordic_z;
    dso_pkg::unit_stat_t         cordic_stat;

    logic in_take;
    logic out_free;

    assign s_ready   = (state_reg == ST_IDLE) && !norm_stat.busy && !cordic_stat.busy;
    assign cfg_ready = 1'b1;
    assign in_take   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    dso_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (norm_start),
        .a_in    (norm_a_in),
        .b_in    (norm_b_in),
        .stat    (norm_stat),
        .a_out   (norm_a),
        .b_out   (norm_b)
    );

    dso_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .x_in    (dso_pkg::CORDIC_W'(norm_a)),
        .y_in    (dso_pkg::CORDIC_W'(norm_b)),
        .z_in    (z0_reg),
        .stat    (cordic_stat),
        .z_out   (cordic_z)
    );

    always_comb begin
        dy_raw = dso_pkg::DY_W'(ly_reg) - dso_pkg::DY_W'(ry_reg);
        dx_neg = -dx_reg;
        // clamp the angle to 0..pi, then round half up to pi/32768 units
        if (cordic_z < 0) begin
            z_clamp = '0;
        end else if (cordic_z > dso_pkg::Z_PI) begin
            z_clamp = dso_pkg::Z_PI;
        end else begin
            z_clamp = cordic_z;
        end
        z_round = z_clamp + ROUND_HALF;
    end

    always_comb begin
        state_next    = state_reg;
        lx_next       = lx_reg;
        ly_next       = ly_reg;
        rx_next       = rx_reg;
        ry_next       = ry_reg;
        sep_next      = sep_reg;
        last_yaw_next = last_yaw_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        z0_next       = z0_reg;
        sum_x_next    = sum_x_reg;
        sum_y_next    = sum_y_reg;
        yaw_next      = yaw_reg;
        degen_next    = degen_reg;
        m_valid_next  = m_valid_reg;
        m_x_next      = m_x_reg;
        m_y_next      = m_y_reg;
        m_yaw_next    = m_yaw_reg;
        m_degen_next  = m_degen_reg;
        norm_start    = 1'b0;
        norm_a_in     = '0;
        norm_b_in     = '0;
        cordic_start  = 1'b0;

        if (cfg_valid) begin
            sep_next = cfg_data;
        end

        // drop the shown result once it is taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_take) begin
                    lx_next    = sat_add(lx_reg, s_left_dx);
                    ly_next    = sat_add(ly_reg, s_left_dy);
                    rx_next    = sat_add(rx_reg, s_right_dx);
                    ry_next    = sat_add(ry_reg, s_right_dy);
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: begin
                // separation cancels in the x sum; dx carries it live
                dx_next    = dso_pkg::DX_W'($signed({1'b0, sep_reg}))
                           + dso_pkg::DX_W'(lx_reg) - dso_pkg::DX_W'(rx_reg);
                dy_next    = dy_raw[dso_pkg::DY_W-1] ? unsigned'(-dy_raw) : unsigned'(dy_raw);
                sum_x_next = sum_sat(lx_reg, rx_reg);
                sum_y_next = sum_sat(ly_reg, ry_reg);
                state_next = ST_SORT;
            end
            ST_SORT: begin
                degen_next = 1'b0;
                state_next = ST_FIN;
                if (dx_reg == '0 && dy_reg == '0) begin
                    // coinciding sensors: hold the last heading
                    degen_next = 1'b1;
                    yaw_next   = last_yaw_reg;
                end else if (dy_reg == '0) begin
                    yaw_next = (dx_reg > 0) ? dso_pkg::YAW_ZERO : dso_pkg::YAW_PI;
                end else if (dx_reg == '0) begin
                    yaw_next = dso_pkg::YAW_HALF_PI;
                end else if (dx_reg > 0) begin
                    norm_start = 1'b1;
                    norm_a_in  = dso_pkg::NORM_W'(unsigned'(dx_reg));
                    norm_b_in  = dso_pkg::NORM_W'(dy_reg);
                    z0_next    = '0;
                    state_next = ST_NORM;
                end else begin
                    // left half plane: turn by -pi/2 first
                    norm_start = 1'b1;
                    norm_a_in  = dso_pkg::NORM_W'(dy_reg);
                    norm_b_in  = dso_pkg::NORM_W'(dx_neg);
                    z0_next    = dso_pkg::Z_HALF_PI;
                    state_next = ST_NORM;
                end
            end
            ST_NORM: begin
                if (norm_stat.done) begin
                    cordic_start = 1'b1;
                    state_next   = ST_ROT;
                end
            end
            ST_ROT: begin
                if (cordic_stat.done) begin
                    yaw_next   = z_round[31:16];
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                // hold until the output register is free
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_x_next      = sum_x_reg;
                    m_y_next      = sum_y_reg;
                    m_yaw_next    = yaw_reg;
                    m_degen_next  = degen_reg;
                    last_yaw_next = yaw_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        z0_reg      <= z0_next;
        sum_x_reg   <= sum_x_next;
        sum_y_reg   <= sum_y_next;
        yaw_reg     <= yaw_next;
        degen_reg   <= degen_next;
        m_x_reg     <= m_x_next;
        m_y_reg     <= m_y_next;
        m_yaw_reg   <= m_yaw_next;
        m_degen_reg <= m_degen_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            lx_reg       <= '0;
            ly_reg       <= '0;
            rx_reg       <= '0;
            ry_reg       <= '0;
            sep_reg      <= dso_pkg::SEP_W'(100);
            last_yaw_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            lx_reg       <= lx_next;
            ly_reg       <= ly_next;
            rx_reg       <= rx_next;
            ry_reg       <= ry_next;
            sep_reg      <= sep_next;
            last_yaw_reg <= last_yaw_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_mid_x_sum  = m_x_reg;
    assign m_mid_y_sum  = m_y_reg;
    assign m_yaw_code   = m_yaw_reg;
    assign m_degenerate = m_degen_reg;

endmodule

// ===== src/dso_norm.sv =====
// ----------------------------------------------------------------------------
// dso_norm: iterative vector normalizer
// Shifts two magnitudes left together until the larger one reaches the top
// bit, testing one power-of-two shift amount per cycle (32 down to 1).
// ----------------------------------------------------------------------------
module dso_norm (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [dso_pkg::NORM_W-1:0]  a_in,
    input  logic [dso_pkg::NORM_W-1:0]  b_in,
    output dso_pkg::unit_stat_t         stat,
    output logic [dso_pkg::NORM_W-1:0]  a_out,
    output logic [dso_pkg::NORM_W-1:0]  b_out
);

    logic [dso_pkg::NORM_W-1:0] a_reg, a_next;
    logic [dso_pkg::NORM_W-1:0] b_reg, b_next;
    logic [dso_pkg::NSTG_W-1:0] stage_reg, stage_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;

    logic [dso_pkg::NSH_W-1:0]  shamt;
    logic [dso_pkg::NORM_W-1:0] or_w;
    logic                       fits;

    always_comb begin
        shamt = dso_pkg::NSH_W'(1) << (dso_pkg::NSTG_W'(dso_pkg::NORM_STAGES - 1) - stage_reg);
        or_w  = a_reg | b_reg;
        fits  = (or_w >> (dso_pkg::NSH_W'(dso_pkg::NORM_W) - shamt)) == '0;
    end

    always_comb begin
        a_next     = a_reg;
        b_next     = b_reg;
        stage_next = stage_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            a_next     = a_in;
            b_next     = b_in;
            stage_next = '0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            // shift only while the top bit stays inside the word
            if (fits) begin
                a_next = a_reg << shamt;
                b_next = b_reg << shamt;
            end
            if (stage_reg == dso_pkg::NSTG_W'(dso_pkg::NORM_STAGES - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                stage_next = stage_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        stage_reg <= stage_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign a_out     = a_reg;
    assign b_out     = b_reg;

endmodule

// ===== src/dso_cordic.sv =====
// ----------------------------------------------------------------------------
// dso_cordic: iterative CORDIC vectoring unit
// One shift-add micro-rotation per cycle drives y toward zero and
// accumulates the angle from the arctangent table.
// ----------------------------------------------------------------------------
module dso_cordic (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [dso_pkg::CORDIC_W-1:0] x_in,
    input  logic signed [dso_pkg::CORDIC_W-1:0] y_in,
    input  logic signed [dso_pkg::Z_W-1:0]      z_in,
    output dso_pkg::unit_stat_t               stat,
    output logic signed [dso_pkg::Z_W-1:0]      z_out
);

    logic signed [dso_pkg::CORDIC_W-1:0] x_reg, x_next;
    logic signed [dso_pkg::CORDIC_W-1:0] y_reg, y_next;
    logic signed [dso_pkg::Z_W-1:0]      z_reg, z_next;
    logic [dso_pkg::STEP_W-1:0]          step_reg, step_next;
    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;

    logic signed [dso_pkg::CORDIC_W-1:0] xs, ys;
    logic signed [dso_pkg::Z_W-1:0]      angle;

    always_comb begin
        xs    = x_reg >>> step_reg;
        ys    = y_reg >>> step_reg;
        angle = dso_pkg::atan_entry(dso_pkg::TAB_IDX_W'(step_reg));
    end

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            x_next    = x_in;
            y_next    = y_in;
            z_next    = z_in;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!y_reg[dso_pkg::CORDIC_W-1]) begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + angle;
            end else begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - angle;
            end
            if (step_reg == dso_pkg::STEP_W'(dso_pkg::CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        step_reg <= step_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign z_out     = z_reg;

endmodule

// ===== sim/tb_dual_sensor_odometry_pose.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for dual_sensor_odometry_pose
// Drives shift items through the valid/ready input channel, rewrites the
// sensor spacing between phases, and checks every result item against a
// cycle-free model of the accumulators and the CORDIC heading.
// ----------------------------------------------------------------------------
module tb;

    typedef struct {
        logic signed [dso_pkg::IN_W-1:0] ldx;
        logic signed [dso_pkg::IN_W-1:0] ldy;
        logic signed [dso_pkg::IN_W-1:0] rdx;
        logic signed [dso_pkg::IN_W-1:0] rdy;
    } shift_t;

    typedef struct {
        logic signed [dso_pkg::SUM_W-1:0] x_sum;
        logic signed [dso_pkg::SUM_W-1:0] y_sum;
        logic [dso_pkg::YAW_W-1:0]        yaw;
        logic                             degen;
    } pose_t;

    localparam longint ACC_MAX = (longint'(1) <<< (dso_pkg::ACC_WIDTH - 1)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam longint SUM_MAX = (longint'(1) <<< (dso_pkg::SUM_W - 1)) - 1;
    localparam longint SUM_MIN = -SUM_MAX - 1;
    localparam int     MAX_PRINTED = 50;

    // DUT ports; every input starts at a known value
    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic signed [dso_pkg::IN_W-1:0]  s_left_dx = '0;
    logic signed [dso_pkg::IN_W-1:0]  s_left_dy = '0;
    logic signed [dso_pkg::IN_W-1:0]  s_right_dx = '0;
    logic signed [dso_pkg::IN_W-1:0]  s_right_dy = '0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic signed [dso_pkg::SUM_W-1:0] m_mid_x_sum;
    logic signed [dso_pkg::SUM_W-1:0] m_mid_y_sum;
    logic [dso_pkg::YAW_W-1:0]        m_yaw_code;
    logic                             m_degenerate;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [dso_pkg::SEP_W-1:0]        cfg_data = '0;

    // Predicted block state, advanced once per accepted item
    longint                    acc_lx = 0;
    longint                    acc_ly = 0;
    longint                    acc_rx = 0;
    longint                    acc_ry = 0;
    logic [dso_pkg::YAW_W-1:0] held_yaw = '0;
    logic [dso_pkg::SEP_W-1:0] spacing = 16'd100;

    // Planning copy of the accumulators, advanced as items are queued; it
    // lets the stimulus steer the vector onto the axes and onto zero.
    longint plan_lx = 0;
    longint plan_ly = 0;
    longint plan_rx = 0;
    longint plan_ry = 0;

    longint atan_tab [0:23] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    shift_t      shift_q [$];   // items waiting for the driver
    pose_t       pose_q [$];    // predicted results, oldest first
    shift_t      next_shift;
    shift_t      taken_shift;
    pose_t       want_pose;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int          n_offered = 0;
    int          n_taken = 0;
    int          n_results = 0;
    int          n_writes = 0;
    int          n_degen = 0;
    int          n_axis = 0;
    int          n_rotated = 0;
    int          errors = 0;

    dual_sensor_odometry_pose uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_left_dx    (s_left_dx),
        .s_left_dy    (s_left_dy),
        .s_right_dx   (s_right_dx),
        .s_right_dy   (s_right_dy),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_mid_x_sum  (m_mid_x_sum),
        .m_mid_y_sum  (m_mid_y_sum),
        .m_yaw_code   (m_yaw_code),
        .m_degenerate (m_degenerate),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Model arithmetic
    // ------------------------------------------------------------------
    function automatic longint sat_acc(input longint acc, input longint delta);
        longint s;
        s = acc + delta;
        if (s > ACC_MAX) s = ACC_MAX;
        if (s < ACC_MIN) s = ACC_MIN;
        return s;
    endfunction

    function automatic logic signed [dso_pkg::SUM_W-1:0] pair_sum(input longint a,
                                                                  input longint b);
        longint s;
        s = a + b;
        if (s > SUM_MAX) s = SUM_MAX;
        if (s < SUM_MIN) s = SUM_MIN;
        return dso_pkg::SUM_W'(s);
    endfunction

    // Heading of (vx, vy) with vy already made nonnegative; angle word in
    // units of pi/2^31, rounded half up to pi/32768 at the end.
    function automatic logic [dso_pkg::YAW_W-1:0] cordic_heading(input longint vx,
                                                                 input longint vy);
        longint          x, y, z, xs, ys;
        longint unsigned ux, uy;
        if (vy == 0) return (vx > 0) ? dso_pkg::YAW_ZERO : dso_pkg::YAW_PI;
        if (vx == 0) return dso_pkg::YAW_HALF_PI;
        if (vx > 0) begin
            ux = vx;
            uy = vy;
            z  = 0;
        end else begin
            // turn by -pi/2 so the vector lands in the right half plane
            ux = vy;
            uy = -vx;
            z  = dso_pkg::Z_HALF_PI;
        end
        while ((ux | uy) < (64'd1 << 59)) begin
            ux = ux << 1;
            uy = uy << 1;
        end
        x = longint'(ux);
        y = longint'(uy);
        for (int i = 0; i < dso_pkg::CORDIC_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_tab[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_tab[i];
            end
        end
        if (z < 0) z = 0;
        if (z > longint'(dso_pkg::Z_PI)) z = dso_pkg::Z_PI;
        return dso_pkg::YAW_W'((z + 32768) >>> 16);
    endfunction

    // Advance the predicted state by one item and return its result.
    function automatic pose_t advance_pose(input shift_t s);
        pose_t  r;
        longint vx, vy;
        acc_lx = sat_acc(acc_lx, s.ldx);
        acc_ly = sat_acc(acc_ly, s.ldy);
        acc_rx = sat_acc(acc_rx, s.rdx);
        acc_ry = sat_acc(acc_ry, s.rdy);
        vx = longint'({48'b0, spacing}) + acc_lx - acc_rx;
        vy = acc_ly - acc_ry;
        if (vy < 0) vy = -vy;
        r.degen = (vx == 0 && vy == 0);
        if (r.degen) begin
            n_degen++;
        end else begin
            if (vx == 0 || vy == 0) n_axis++;
            else n_rotated++;
            held_yaw = cordic_heading(vx, vy);
        end
        r.yaw   = held_yaw;
        r.x_sum = pair_sum(acc_lx, acc_rx);
        r.y_sum = pair_sum(acc_ly, acc_ry);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------
    task automatic report(input string msg);
        if (errors < MAX_PRINTED) $display("MISMATCH: %s", msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic signed [63:0] got,
                               input logic signed [63:0] want);
        if (got !== want)
            report($sformatf("result %0d: %s is %0d, predicted %0d",
                             n_results, name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Driver: present queued items at the falling edge, idle at random.
    // An item stays on the bus until the monitor has seen it accepted.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
        if (!s_valid || n_taken == n_offered) begin
            if (aresetn && shift_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_shift = shift_q.pop_front();
                s_left_dx  <= next_shift.ldx;
                s_left_dy  <= next_shift.ldy;
                s_right_dx <= next_shift.rdx;
                s_right_dy <= next_shift.rdy;
                s_valid    <= 1'b1;
                n_offered++;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted input item, then compare every
    // accepted result item against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            taken_shift.ldx = s_left_dx;
            taken_shift.ldy = s_left_dy;
            taken_shift.rdx = s_right_dx;
            taken_shift.rdy = s_right_dy;
            pose_q.push_back(advance_pose(taken_shift));
            n_taken++;
        end
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (pose_q.size() == 0) begin
                report($sformatf("result %0d arrived with no item outstanding", n_results));
            end else begin
                want_pose = pose_q.pop_front();
                check_field("mid_x_sum", m_mid_x_sum, want_pose.x_sum);
                check_field("mid_y_sum", m_mid_y_sum, want_pose.y_sum);
                check_field("yaw_code", m_yaw_code, want_pose.yaw);
                check_field("degenerate", m_degenerate, want_pose.degen);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic shift_t shift_of(input int ldx, input int ldy, input int rdx,
                                        input int rdy);
        shift_t s;
        s.ldx = dso_pkg::IN_W'(ldx);
        s.ldy = dso_pkg::IN_W'(ldy);
        s.rdx = dso_pkg::IN_W'(rdx);
        s.rdy = dso_pkg::IN_W'(rdy);
        return s;
    endfunction

    function automatic logic signed [dso_pkg::IN_W-1:0] clip16(input longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return dso_pkg::IN_W'(v);
    endfunction

    // Queue an item and advance the planning copy with it.
    function automatic void queue_shift(input shift_t s);
        shift_q.push_back(s);
        plan_lx = sat_acc(plan_lx, s.ldx);
        plan_ly = sat_acc(plan_ly, s.ldy);
        plan_rx = sat_acc(plan_rx, s.rdx);
        plan_ry = sat_acc(plan_ry, s.rdy);
    endfunction

    // Mostly full-range shifts; the rest are small steps, zero items, and
    // items that steer the vector toward an axis or onto zero.
    function automatic shift_t random_shift();
        shift_t      s;
        int unsigned kind;
        longint      gap_x, gap_y;
        s.ldx = dso_pkg::IN_W'($urandom);
        s.ldy = dso_pkg::IN_W'($urandom);
        s.rdx = dso_pkg::IN_W'($urandom);
        s.rdy = dso_pkg::IN_W'($urandom);
        kind  = $urandom_range(99);
        gap_x = -(longint'({48'b0, spacing}) + plan_lx - plan_rx);
        gap_y = plan_ry - plan_ly;
        if (kind < 20) begin
            s.ldx = dso_pkg::IN_W'(int'($urandom_range(16)) - 8);
            s.ldy = dso_pkg::IN_W'(int'($urandom_range(16)) - 8);
            s.rdx = dso_pkg::IN_W'(int'($urandom_range(16)) - 8);
            s.rdy = dso_pkg::IN_W'(int'($urandom_range(16)) - 8);
        end else if (kind < 30) begin
            s = shift_of(clip16(gap_x), clip16(gap_y), 0, 0);
        end else if (kind < 38) begin
            s.ldy = clip16(gap_y);
            s.rdy = '0;
        end else if (kind < 46) begin
            s.ldx = clip16(gap_x);
            s.rdx = '0;
        end else if (kind < 50) begin
            s = shift_of(0, 0, 0, 0);
        end
        return s;
    endfunction

    // Hold until nothing is queued, on the bus or predicted.
    task automatic settle();
        do @(negedge aclk);
        while (shift_q.size() != 0 || n_taken != n_offered || pose_q.size() != 0);
    endtask

    // Write the spacing register; only called with the block idle.
    task automatic write_spacing(input logic [dso_pkg::SEP_W-1:0] value);
        @(negedge aclk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk);
        while (!cfg_ready);
        spacing = value;
        n_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [dso_pkg::SEP_W-1:0] sep,
                             input int unsigned idle_pct,
                             input int unsigned stall_pct, input int count);
        write_spacing(sep);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) queue_shift(random_shift());
        settle();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset spacing of 100
        queue_shift(shift_of(-100, 0, 0, 0));    // coinciding at once: hold reset yaw
        queue_shift(shift_of(100, 0, 0, 0));     // on the +x axis
        queue_shift(shift_of(0, 50, 0, 0));      // general case, dx positive
        queue_shift(shift_of(-100, -50, 0, 0));  // coinciding: hold the CORDIC yaw
        queue_shift(shift_of(0, 0, 0, 20));      // dx zero: quarter turn
        queue_shift(shift_of(0, 0, 0, -20));     // coinciding again
        queue_shift(shift_of(-5, 0, 0, 0));      // on the -x axis
        queue_shift(shift_of(0, 0, 0, 7));       // general case, dx negative
        queue_shift(shift_of(5, 0, 0, -7));      // coinciding after a negative-dx yaw
        queue_shift(shift_of(0, 0, 100, 0));     // -x axis via the right sensor
        queue_shift(shift_of(32767, 32767, -32768, -32768));
        queue_shift(shift_of(-32768, -32768, 32767, 32767));
        queue_shift(shift_of(-1, -1, -1, -1));
        queue_shift(shift_of(1, 1, 0, 0));       // just off the -x axis
        queue_shift(shift_of(0, 0, 0, 32767));
        queue_shift(shift_of(32767, 0, 0, 0));
        queue_shift(shift_of(21845, -21846, -21846, 21845));
        queue_shift(shift_of(-21846, 21845, 21845, -21846));
        settle();

        // Random phases; each drains fully before the next spacing write,
        // so the sender pauses until every result has come back.
        run_phase(16'd0, 0, 0, 330);
        run_phase(16'hFFFF, 64, 0, 330);
        run_phase(dso_pkg::SEP_W'($urandom), 0, 64, 330);
        run_phase(16'd1, 24, 24, 330);

        // Closing random items back at the reset spacing
        write_spacing(16'd100);
        send_idle_pct  = 24;
        recv_stall_pct = 24;
        repeat (100) queue_shift(random_shift());
        settle();
        repeat (40) @(negedge aclk);

        $display("Checked %0d items over %0d spacing writes and four idling mixes.",
                 n_taken, n_writes);
        $display("Headings: %0d coinciding, %0d on an axis, %0d through CORDIC.",
                 n_degen, n_axis, n_rotated);
        if (errors == 0) begin
            $display("dual_sensor_odometry_pose test passed");
        end else begin
            $display("dual_sensor_odometry_pose test failed");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run
    initial begin
        #64000000;
        $display("Timeout with %0d items taken and %0d results seen.", n_taken, n_results);
        $display("dual_sensor_odometry_pose test failed");
        $finish;
    end

endmodule
